// File: src/sma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_pkg
// Shared types and constants of the simple moving average block.
// ----------------------------------------------------------------------------
package sma_pkg;

  localparam int WINDOW_MAX_DEF = 256;
  localparam int PRICE_W        = 32;
  localparam int TAG_W          = 27;
  localparam int WIN_W          = 9;
  localparam int SUM_W          = PRICE_W + WIN_W;

  localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(20);

  typedef struct packed {
    logic signed [PRICE_W-1:0] close_price;
    logic        [TAG_W-1:0]   date_tag;
  } in_item_t;

  typedef struct packed {
    logic signed [PRICE_W-1:0] average;
    logic        [TAG_W-1:0]   result_tag;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV,
    ST_DONE
  } sma_state_t;

endpackage

// File: src/sma_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sma_ram
// Generic single-clock RAM, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module sma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/simple_moving_average.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simple_moving_average
// Moving average of closing prices over a configurable window.
// ----------------------------------------------------------------------------
// One item at a time. An item that completes no window goes through a ring
// read and a read-modify-write of the ring and the running sum before the next
// item can be accepted; one that yields a result also goes through the
// bit-serial restoring divider, which divides the 41-bit sum by the window,
// and the output register load, which waits while an earlier result is
// pending. The result waits in its own register, so the next item is accepted
// while it is pending. A write to the window register restarts averaging.
// Ring entries need no clearing after reset, so the block is ready at once.
module simple_moving_average import sma_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_item,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [WIN_W-1:0] cfg_data
);

  localparam int AW       = $clog2(WINDOW_MAX);
  localparam int CW       = (AW > WIN_W) ? AW : WIN_W;
  localparam int RW       = WIN_W + 1;
  localparam int CNT_W    = $clog2(SUM_W + 1);
  localparam int WinCap   = (WINDOW_MAX < (2**WIN_W - 1)) ? WINDOW_MAX : (2**WIN_W - 1);
  localparam logic [WIN_W-1:0] WIN_CAP  = WIN_W'(WinCap);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(SUM_W - 1);

  sma_state_t state_r, state_nxt;

  logic [WIN_W-1:0]   window_r;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [WIN_W-1:0]   fill_r, fill_nxt;
  logic [AW-1:0]      ptr_r, ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [RW-1:0]      rem_r, rem_nxt;
  logic [SUM_W-1:0]   quo_r, quo_nxt;
  logic               neg_r, neg_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;
  logic [PRICE_W-1:0] price_r;
  logic [TAG_W-1:0]   tag_r;

  logic [WIN_W-1:0]   win;
  logic [AW-1:0]      slot;
  logic [CW:0]        slot_inc;
  logic               full;
  logic [SUM_W-1:0]   old_ext;
  logic [SUM_W-1:0]   new_ext;
  logic [SUM_W-1:0]   sum_upd;
  logic [SUM_W-1:0]   sum_abs;
  logic [RW:0]        rem_shift;
  logic [RW:0]        rem_diff;
  logic [PRICE_W-1:0] quo_low;
  logic               ring_we;
  logic [PRICE_W-1:0] ring_rdata;
  logic               in_fire;
  logic               cfg_fire;

  sma_ram #(
    .WIDTH (PRICE_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (slot),
    .wdata (price_r),
    .raddr (slot),
    .rdata (ring_rdata)
  );

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign win = (window_r == '0) ? WIN_W'(1) :
               ((window_r > WIN_CAP) ? WIN_CAP : window_r);

  assign slot     = (CW'(ptr_r) >= CW'(win)) ? '0 : ptr_r;
  assign slot_inc = (CW + 1)'(slot) + (CW + 1)'(1);
  assign full     = (fill_r >= win);
  assign old_ext  = {{(SUM_W - PRICE_W){ring_rdata[PRICE_W-1]}}, ring_rdata};
  assign new_ext  = {{(SUM_W - PRICE_W){price_r[PRICE_W-1]}}, price_r};
  assign sum_upd  = sum_r - (full ? old_ext : '0) + new_ext;
  assign sum_abs  = sum_upd[SUM_W-1] ? (~sum_upd + SUM_W'(1)) : sum_upd;
  assign rem_shift = {rem_r, quo_r[SUM_W-1]};
  assign rem_diff  = rem_shift - (RW + 1)'(win);
  assign quo_low   = quo_r[PRICE_W-1:0];
  assign ring_we   = (state_r == ST_UPDATE);

  always_comb begin
    state_nxt     = state_r;
    sum_nxt       = sum_r;
    fill_nxt      = fill_r;
    ptr_nxt       = ptr_r;
    cnt_nxt       = cnt_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        sum_nxt  = sum_upd;
        fill_nxt = full ? fill_r : fill_r + WIN_W'(1);
        ptr_nxt  = (slot_inc >= (CW + 1)'(win)) ? '0 : AW'(slot_inc);
        if (fill_nxt >= win) begin
          quo_nxt   = sum_abs;
          neg_nxt   = sum_upd[SUM_W-1];
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_DIV: begin
        if (rem_shift >= (RW + 1)'(win)) begin
          rem_nxt = RW'(rem_diff);
          quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = RW'(rem_shift);
          quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt           = 1'b1;
          out_item_nxt.average    = neg_r ? (~quo_low + PRICE_W'(1)) : quo_low;
          out_item_nxt.result_tag = tag_r;
          state_nxt               = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (cfg_fire) begin
      sum_nxt  = '0;
      fill_nxt = '0;
      ptr_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      window_r    <= WINDOW_RESET;
      sum_r       <= '0;
      fill_r      <= '0;
      ptr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      fill_r      <= fill_nxt;
      ptr_r       <= ptr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_fire) begin
        window_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    neg_r      <= neg_nxt;
    out_item_r <= out_item_nxt;
    if (in_fire) begin
      price_r <= in_item.close_price;
      tag_r   <= in_item.date_tag;
    end
  end

  // a new result only comes out of the divider's final state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside the done state");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= win)
    else $error("fill count above the window");

  a_ptr_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPDATE) |=> (CW'(ptr_r) < CW'(win)) || $past(cfg_fire))
    else $error("write pointer outside the window");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r <= DIV_LAST))
    else $error("divider step count overrun");

endmodule
